// ===== hdl/dtdn_pkg.sv =====
// shared types, constants and tables for the text to day number block
// no dependencies

package dtdn_pkg;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;

  localparam logic [3:0] PosMonthDash = 4'd4;
  localparam logic [3:0] PosDayDash   = 4'd7;
  localparam logic [3:0] DateLen      = 4'd10;
  localparam logic [3:0] CountMax     = 4'd15;

  localparam logic [34:0] IntLimit = 35'd2147483648;

  localparam logic signed [23:0] DaysPerCentury = 24'sd36524;
  localparam logic [15:0]        DaysPerYear    = 16'd365;
  localparam logic [23:0]        EpochOffset    = 24'd719468;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_CHECK,
    ST_MUL,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic take_byte;
    logic prep;
    logic mul;
    logic load_out;
  } cmd_t;

  // days in a non-leap month, month 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days from march 1 to the first of the month
  function automatic logic [8:0] march_offset(input logic [3:0] month);
    logic [8:0] off;
    case (month)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/dtdn_ctrl.sv =====
// controller: receive state, three compute steps, output register handshake
// depends on dtdn_pkg

module dtdn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_no_char_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output dtdn_pkg::cmd_t cmd_o
);
  import dtdn_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RECV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_RECV: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_valid_i && !in_no_char_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        // wait here until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_RECV;
        end
      end
      default: state_d = ST_RECV;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/dtdn_dp.sv =====
// datapath: per-byte parse state, date check, day count arithmetic, result register
// depends on dtdn_pkg

module dtdn_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dtdn_pkg::cmd_t cmd_i,
  input  logic [7:0]    char_code_i,
  output logic          valid_res_o,
  output logic [31:0]   day_number_o
);
  import dtdn_pkg::*;

  // parse state
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] mag_q, mag_d;
  logic        ovf_q, ovf_d;
  logic        int_form_q, int_form_d;
  logic        seen_q, seen_d;
  logic        neg_q, neg_d;
  logic        date_form_q, date_form_d;
  logic [6:0]  cen_q, cen_d;
  logic [6:0]  yy_q, yy_d;
  logic [6:0]  mon_q, mon_d;
  logic [6:0]  day_q, day_d;

  // compute stages
  logic        int_ok_q, int_ok_d;
  logic [31:0] int_val_q, int_val_d;
  logic        date_ok_q, date_ok_d;
  logic [7:0]  cy_q, cy_d;
  logic [6:0]  yy2_q, yy2_d;
  logic [8:0]  doy_q, doy_d;
  logic signed [23:0] p1_q, p1_d;
  logic [15:0] p2_q, p2_d;
  logic signed [23:0] small_q, small_d;
  logic        res_valid_q, res_valid_d;
  logic [31:0] res_day_q, res_day_d;

  logic        is_digit;
  logic [3:0]  digit;
  logic [34:0] mag_next;
  logic        leap;
  logic        mon_ok;
  logic [5:0]  mlen;
  logic        adj;
  logic        borrow;
  logic signed [23:0] cy_ext;
  logic signed [23:0] sum_w;

  assign is_digit = char_code_i inside {[CharZero:CharNine]};
  assign digit    = is_digit ? 4'(char_code_i - CharZero) : 4'd0;
  assign mag_next = ({3'b0, mag_q} << 3) + ({3'b0, mag_q} << 1) + {31'b0, digit};

  always_comb begin
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    ovf_d       = ovf_q;
    int_form_d  = int_form_q;
    seen_d      = seen_q;
    neg_d       = neg_q;
    date_form_d = date_form_q;
    cen_d       = cen_q;
    yy_d        = yy_q;
    mon_d       = mon_q;
    day_d       = day_q;
    if (cmd_i.load_out) begin
      cnt_d       = '0;
      mag_d       = '0;
      ovf_d       = 1'b0;
      int_form_d  = 1'b1;
      seen_d      = 1'b0;
      neg_d       = 1'b0;
      date_form_d = 1'b1;
      cen_d       = '0;
      yy_d        = '0;
      mon_d       = '0;
      day_d       = '0;
    end else if (cmd_i.take_byte) begin
      // integer form
      if (is_digit) begin
        seen_d = 1'b1;
        if (!ovf_q) begin
          if (mag_next > IntLimit) begin
            ovf_d = 1'b1;
          end else begin
            mag_d = mag_next[31:0];
          end
        end
      end else if (cnt_q == '0 && (char_code_i inside {CharMinus, CharPlus})) begin
        neg_d = (char_code_i == CharMinus);
      end else begin
        int_form_d = 1'b0;
      end
      // date form, year kept as century and year of century
      if (cnt_q >= DateLen) begin
        date_form_d = 1'b0;
      end else if (cnt_q inside {PosMonthDash, PosDayDash}) begin
        if (char_code_i != CharMinus) begin
          date_form_d = 1'b0;
        end
      end else if (!is_digit) begin
        date_form_d = 1'b0;
      end else if (cnt_q < 4'd2) begin
        cen_d = (cen_q << 3) + (cen_q << 1) + {3'b0, digit};
      end else if (cnt_q < PosMonthDash) begin
        yy_d = (yy_q << 3) + (yy_q << 1) + {3'b0, digit};
      end else if (cnt_q < PosDayDash) begin
        mon_d = (mon_q << 3) + (mon_q << 1) + {3'b0, digit};
      end else begin
        day_d = (day_q << 3) + (day_q << 1) + {3'b0, digit};
      end
      if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      mag_q       <= '0;
      ovf_q       <= 1'b0;
      int_form_q  <= 1'b1;
      seen_q      <= 1'b0;
      neg_q       <= 1'b0;
      date_form_q <= 1'b1;
      cen_q       <= '0;
      yy_q        <= '0;
      mon_q       <= '0;
      day_q       <= '0;
    end else begin
      cnt_q       <= cnt_d;
      mag_q       <= mag_d;
      ovf_q       <= ovf_d;
      int_form_q  <= int_form_d;
      seen_q      <= seen_d;
      neg_q       <= neg_d;
      date_form_q <= date_form_d;
      cen_q       <= cen_d;
      yy_q        <= yy_d;
      mon_q       <= mon_d;
      day_q       <= day_d;
    end
  end

  // check step
  assign leap   = (yy_q != '0) ? (yy_q[1:0] == 2'b00) : (cen_q[1:0] == 2'b00);
  assign mon_ok = mon_q inside {[7'd1:7'd12]};
  assign mlen   = {1'b0, month_len(mon_q[3:0])} + {5'b0, (leap && mon_q == 7'd2)};
  assign adj    = (mon_q <= 7'd2);
  assign borrow = adj && (yy_q == '0);

  always_comb begin
    int_ok_d  = int_form_q && seen_q && !ovf_q &&
                (!mag_q[31] || (neg_q && mag_q[30:0] == '0));
    int_val_d = neg_q ? (32'd0 - mag_q) : mag_q;
    date_ok_d = date_form_q && (cnt_q == DateLen) && mon_ok &&
                (day_q != '0) && ({1'b0, day_q} <= {2'b0, mlen});
    // shifted year as 100 * cy + yy2, cy may reach -1
    cy_d      = {1'b0, cen_q} - {7'b0, borrow};
    yy2_d     = borrow ? 7'd99 : (yy_q - {6'b0, adj});
    doy_d     = march_offset(mon_q[3:0]) + {2'b0, day_q} - 9'd1;
  end

  // multiply step
  assign cy_ext = {{16{cy_q[7]}}, cy_q};

  always_comb begin
    p1_d    = cy_ext * DaysPerCentury;
    p2_d    = {9'b0, yy2_q} * DaysPerYear;
    small_d = {{18{cy_q[7]}}, cy_q[7:2]} + {19'b0, yy2_q[6:2]} + {15'b0, doy_q} - EpochOffset;
  end

  // sum step and result select
  assign sum_w = p1_q + $signed({8'b0, p2_q}) + small_q;

  always_comb begin
    res_valid_d = int_ok_q || date_ok_q;
    if (int_ok_q) begin
      res_day_d = int_val_q;
    end else if (date_ok_q) begin
      res_day_d = {{8{sum_w[23]}}, sum_w};
    end else begin
      res_day_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      int_ok_q  <= int_ok_d;
      int_val_q <= int_val_d;
      date_ok_q <= date_ok_d;
      cy_q      <= cy_d;
      yy2_q     <= yy2_d;
      doy_q     <= doy_d;
    end
    if (cmd_i.mul) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      small_q <= small_d;
    end
    if (cmd_i.load_out) begin
      res_valid_q <= res_valid_d;
      res_day_q   <= res_day_d;
    end
  end

  assign valid_res_o  = res_valid_q;
  assign day_number_o = res_day_q;

endmodule

// ===== hdl/date_text_to_day_number.sv =====
// top level of the text to day number block
// depends on dtdn_pkg, dtdn_ctrl and dtdn_dp

// Takes a text one byte per item on the slave stream, with tlast on the final
// item, and gives one result item per text. A text that is a signed decimal
// integer fitting 32 bits gives that integer; otherwise a text of the exact
// form yyyy-MM-dd with a real calendar date (proleptic gregorian, years 0000
// to 9999) gives days since 1970-01-01; anything else gives tuser = 0 and
// data zero. Bytes are taken one per cycle while the receive state is active.
// After the item with tlast the block stops taking bytes and runs the check
// and multiply steps of the day count, then the sum step, which loads the
// result register, and then it takes the next text. The result register lets
// the next text stream in while a result still waits; the sum step holds only
// if that register is still occupied.
module date_text_to_day_number (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] no_char
  input  logic        s_axis_tlast,   // last
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] day_number, signed
  output logic        m_axis_tuser    // [0] valid_res
);
  import dtdn_pkg::*;

  cmd_t cmd;

  // sequencer: receive, check, multiply, sum
  dtdn_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_no_char_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .in_ready_o   (s_axis_tready),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .cmd_o        (cmd)
  );

  // parse state and day count arithmetic
  dtdn_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .char_code_i  (s_axis_tdata),
    .valid_res_o  (m_axis_tuser),
    .day_number_o (m_axis_tdata)
  );

endmodule

// ===== hdl/dtdn_chk.sv =====
// port-level checker for the text to day number block, bound to the top level
// depends on date_text_to_day_number

module dtdn_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // rejected text carries zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("invalid result with nonzero day number");

  // input closes while the day count is worked out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken during compute steps");

  // a new result only shows after a compute step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without compute");

endmodule

bind date_text_to_day_number dtdn_chk u_dtdn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
